@@ design/priority_class_job_queues_defines.svh @@
// Assertion macros for the priority class job queues.
`ifndef PRIORITY_CLASS_JOB_QUEUES_DEFINES_SVH
`define PRIORITY_CLASS_JOB_QUEUES_DEFINES_SVH

`ifndef SYNTHESIS
`define PCJQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcjq assertion failed");
`define PCJQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcjq assertion failed");
`else
`define PCJQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PCJQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ design/pcjq_pkg.sv @@
// Shared types and constants for the priority class job queues.
`default_nettype none

package pcjq_pkg;

  localparam int NUM_CLASSES_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int MAX_FALLBACKS_DEF = 3;
  localparam int JOB_ID_BITS_DEF   = 16;

  // fallback fields present in a command
  localparam int FALLBACK_FIELDS = 3;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] job_id;
    logic [1:0]  class_sel;
    logic [1:0]  fallback_count;
    logic [1:0]  fallback_a;
    logic [1:0]  fallback_b;
    logic [1:0]  fallback_c;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [15:0] out_job;
    logic [1:0]  served_class;
    logic        notify;
    logic        dropped;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qs_op_t;

  typedef struct packed {
    logic in_range;
    logic has_job;
    logic has_room;
  } qs_stat_t;

endpackage

`default_nettype wire

@@ design/pcjq_store.sv @@
// Job identifier memory, one region per class, registered read.
`default_nettype none

module pcjq_store #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/pcjq_qstate.sv @@
// Per-class head pointers and occupancy counts with a single class probe.
`default_nettype none

module pcjq_qstate #(
  parameter int NUM_CLASSES = pcjq_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = pcjq_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        cls,
  input  wire pcjq_pkg::qs_op_t  op,
  output      pcjq_pkg::qs_stat_t stat,
  output      logic [PTR_W-1:0]  head_slot,
  output      logic [PTR_W-1:0]  tail_slot
);

  localparam int CLS_W = $clog2(NUM_CLASSES);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] head_ptr    [NUM_CLASSES];
  logic [CNT_W-1:0] entry_count [NUM_CLASSES];

  logic [CLS_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] head_next;

  assign idx           = CLS_W'(cls);
  assign stat.in_range = (32'(cls) < NUM_CLASSES);
  assign cnt           = entry_count[idx];
  assign head_slot     = head_ptr[idx];
  assign stat.has_job  = stat.in_range && (cnt != '0);
  assign stat.has_room = stat.in_range && (cnt < CNT_W'(QUEUE_DEPTH));

  // head + count stays below twice the depth: one compare and subtract wraps it
  assign tail_sum  = {1'b0, head_slot} + (PTR_W + 1)'(cnt);
  assign tail_slot = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
                   ? PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH))
                   : PTR_W'(tail_sum);
  assign head_next = (head_slot == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_ptr[i]    <= '0;
        entry_count[i] <= '0;
      end
    end else if (op.push && stat.has_room) begin
      entry_count[idx] <= cnt + 1'b1;
    end else if (op.pop && stat.has_job) begin
      head_ptr[idx]    <= head_next;
      entry_count[idx] <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ design/priority_class_job_queues.sv @@
// Top level: command sequencer, class probe, job memory and result register.
`default_nettype none
`include "priority_class_job_queues_defines.svh"

// One FIFO of job identifiers per priority class. A push writes the job
// in S_PUSH. A pop or query probes one class per cycle (preferred class
// first, then each valid fallback) through a single count compare unit,
// then reads the job from the registered memory in S_FETCH when one is
// found. The result register holds a finished result while the next
// command is taken; a result finishing while the previous one still waits
// parks until the output frees up.
module priority_class_job_queues #(
  parameter int NUM_CLASSES   = pcjq_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH   = pcjq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_FALLBACKS = pcjq_pkg::MAX_FALLBACKS_DEF,
  parameter int JOB_ID_BITS   = pcjq_pkg::JOB_ID_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output      logic              cmd_ready,
  input  wire pcjq_pkg::cmd_t    cmd,
  output      logic              result_valid,
  input  wire logic              result_ready,
  output      pcjq_pkg::result_t result
);

  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = CLS_W + PTR_W;
  localparam int ID_W   = (JOB_ID_BITS < 16) ? JOB_ID_BITS : 16;
  localparam int NFB_LIM_I = (MAX_FALLBACKS < pcjq_pkg::FALLBACK_FIELDS)
                           ? MAX_FALLBACKS : pcjq_pkg::FALLBACK_FIELDS;
  localparam logic [1:0] NFB_LIM = 2'(NFB_LIM_I);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PUSH   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_FETCH  = 5'b01000,
    S_REPLY  = 5'b10000
  } state_t;

  state_t state, state_next;

  pcjq_pkg::cmd_t     req;
  pcjq_pkg::result_t  held;
  pcjq_pkg::result_t  res_next;
  pcjq_pkg::qs_op_t   qs_op;
  pcjq_pkg::qs_stat_t qs_stat;

  logic [1:0]       nfb;
  logic [1:0]       step;
  logic [1:0]       pick;
  logic [1:0]       cand;
  logic [1:0]       qs_cls;
  logic [PTR_W-1:0] head_slot;
  logic [PTR_W-1:0] tail_slot;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ID_W-1:0]  rdata;
  logic             done;
  logic             out_free;
  logic [1:0]       nfb_in;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !result_valid || result_ready;

  assign nfb_in = (cmd.fallback_count > NFB_LIM) ? NFB_LIM : cmd.fallback_count;

  always_comb begin
    unique case (step)
      2'd0: cand = req.class_sel;
      2'd1: cand = req.fallback_a;
      2'd2: cand = req.fallback_b;
      2'd3: cand = req.fallback_c;
      default: cand = req.class_sel;
    endcase
  end

  always_comb begin
    priority case (1'b1)
      state == S_PUSH:   qs_cls = req.class_sel;
      state == S_SEARCH: qs_cls = cand;
      default:           qs_cls = pick;
    endcase
  end

  assign qs_op.push = (state == S_PUSH);
  assign qs_op.pop  = (state == S_FETCH) && (req.command == pcjq_pkg::CMD_POP);

  assign mem_we = (state == S_PUSH) && qs_stat.has_room;
  assign mem_re = (state == S_SEARCH) && qs_stat.has_job;
  assign waddr  = {CLS_W'(req.class_sel), tail_slot};
  assign raddr  = {CLS_W'(cand), head_slot};

  always_comb begin
    state_next = state;
    res_next   = '0;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          priority if (cmd.command == pcjq_pkg::CMD_PUSH) begin
            state_next = S_PUSH;
          end else if (cmd.command == pcjq_pkg::CMD_POP ||
                       cmd.command == pcjq_pkg::CMD_QUERY) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_REPLY;  // unknown command: all-zero result
          end
        end
      end
      S_PUSH: begin
        done                  = 1'b1;
        res_next.served_class = req.class_sel;
        res_next.notify       = qs_stat.has_room;
        res_next.dropped      = !qs_stat.has_room;
      end
      S_SEARCH: begin
        if (qs_stat.has_job) begin
          state_next = S_FETCH;
        end else if (step == nfb) begin
          done = 1'b1;
        end
      end
      S_FETCH: begin
        done                  = 1'b1;
        res_next.found        = 1'b1;
        res_next.out_job      = 16'(rdata);
        res_next.served_class = pick;
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (done) begin
      state_next = out_free ? S_IDLE : S_REPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new result may load in the same cycle the old one transfers out
      if (out_free && (done || state == S_REPLY)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      req  <= cmd;
      held <= '0;
      step <= '0;
      nfb  <= nfb_in;
    end
    if (done && !out_free) begin
      held <= res_next;
    end
    if (state == S_SEARCH) begin
      if (qs_stat.has_job) begin
        pick <= cand;
      end else begin
        step <= step + 1'b1;
      end
    end
    if (out_free) begin
      if (state == S_REPLY) begin
        result <= held;
      end else if (done) begin
        result <= res_next;
      end
    end
  end

  pcjq_qstate #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_qstate (
    .clk       (clk),
    .rst       (rst),
    .cls       (qs_cls),
    .op        (qs_op),
    .stat      (qs_stat),
    .head_slot (head_slot),
    .tail_slot (tail_slot)
  );

  pcjq_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (ID_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (req.job_id[ID_W-1:0]),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  `PCJQ_ASSERT_IMP(a_fetch_has_job, clk, rst, state == S_FETCH, qs_stat.has_job)
  `PCJQ_ASSERT_IMP(a_write_in_room, clk, rst, mem_we, qs_stat.in_range && qs_stat.has_room)
  `PCJQ_ASSERT_IMP(a_result_kind, clk, rst, result_valid, !(result.found && result.dropped))
  `PCJQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

endmodule

`default_nettype wire
